>>> rtl/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and constants for the GIF LZW decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

   localparam int CODE_W  = 12;   // widest LZW code
   localparam int NFC_W   = 13;   // next free code, holds the full table size
   localparam int ACC_W   = 20;   // bit accumulator
   localparam int BCNT_W  = 5;
   localparam int PIX_W   = 25;
   localparam int CBITS_W = 4;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_PUSH  = 2'd1;
   localparam logic [1:0] MODE_PULL  = 2'd2;

   localparam logic [2:0] ST_PIXEL   = 3'd0;
   localparam logic [2:0] ST_NEED    = 3'd1;
   localparam logic [2:0] ST_CONTROL = 3'd2;
   localparam logic [2:0] ST_PAD     = 3'd3;
   localparam logic [2:0] ST_DONE    = 3'd4;
   localparam logic [2:0] ST_OK      = 3'd5;
   localparam logic [2:0] ST_REJECT  = 3'd6;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_POP,
      FSM_WALK_CHK,
      FSM_WALK_DAT,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic accept;
      logic pop_out;
      logic walk_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic go_pop;
      logic go_walk;
      logic walk_more;
   } stat_type;

endpackage

>>> rtl/gld_ram.sv
// ----------------------------------------------------------------------------
// gld_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gld_ctrl.sv
// ----------------------------------------------------------------------------
// gld_ctrl
// Sequencer: accept, stack pop, chain walk and code finish.
// ----------------------------------------------------------------------------
module gld_ctrl
   import gld_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     req_stall,
   output cmd_type  cmd
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = !stat.rsp_free;
            if (req_valid && stat.rsp_free) begin
               cmd.accept = 1'b1;
               if (stat.go_pop) begin
                  state_in = FSM_POP;
               end else if (stat.go_walk) begin
                  state_in = FSM_WALK_CHK;
               end
            end
         end
         FSM_POP: begin
            cmd.pop_out = 1'b1;
            state_in    = FSM_IDLE;
         end
         FSM_WALK_CHK: begin
            // table read of the current link is in flight
            state_in = stat.walk_more ? FSM_WALK_DAT : FSM_FINISH;
         end
         FSM_WALK_DAT: begin
            cmd.walk_step = 1'b1;
            state_in      = FSM_WALK_CHK;
         end
         FSM_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/gld_dpath.sv
// ----------------------------------------------------------------------------
// gld_dpath
// Decoder state, code tables, expansion stack and result word register.
// ----------------------------------------------------------------------------
module gld_dpath
   import gld_pkg::*;
#(
   parameter int TABLE_DEPTH   = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_data_byte,
   input  logic             rsp_stall,
   input  logic             csr_wr_en,
   input  logic [PIX_W-1:0] csr_wr_data,
   output stat_type         stat,
   output logic             rsp_valid,
   output logic [7:0]       rsp_pixel_index,
   output logic [2:0]       rsp_status
);

   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int SAW = $clog2(TABLE_DEPTH + 1);
   localparam int SDW = $clog2(TABLE_DEPTH + 2);

   logic [PIX_W-1:0]   pixel_count_ff, pixel_count_in;
   logic [SDW-1:0]     depth_ff, depth_in;
   logic [CBITS_W-1:0] min_ff, min_in;
   logic [CBITS_W-1:0] ccb_ff, ccb_in;
   logic [NFC_W-1:0]   nfc_ff, nfc_in;
   logic [CODE_W-1:0]  prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic [7:0]         fs_ff, fs_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [BCNT_W-1:0]  bc_ff, bc_in;
   logic [7:0]         sbl_ff, sbl_in;
   logic [PIX_W-1:0]   pixels_ff, pixels_in;
   logic               ended_ff, ended_in;
   logic [CODE_W-1:0]  walk_ff, walk_in;
   logic [CODE_W-1:0]  cur_ff, cur_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_pix_ff, rsp_pix_in;
   logic [2:0]         rsp_st_ff, rsp_st_in;

   logic [NFC_W-1:0]   clear_code, mask, code, nfc_inc, walk13;
   logic               is_done, have_bits, is_pull, dec_clear, dec_stop;
   logic               tbl_we, stk_we;
   logic [SAW-1:0]     stk_waddr;
   logic [7:0]         stk_wdata, stk_rdata, suf_rdata;
   logic [CODE_W-1:0]  pre_rdata;
   logic [SDW-1:0]     depth_m1;

   assign clear_code = NFC_W'(1) << min_ff;
   assign mask       = (NFC_W'(1) << ccb_ff) - NFC_W'(1);
   assign code       = {1'b0, acc_ff[CODE_W-1:0]} & mask;
   assign nfc_inc    = nfc_ff + NFC_W'(1);
   assign walk13     = {1'b0, walk_ff};
   assign depth_m1   = depth_ff - SDW'(1);
   assign is_done    = pixels_ff >= pixel_count_ff;
   assign have_bits  = bc_ff >= {1'b0, ccb_ff};
   assign is_pull    = req_mode == MODE_PULL;
   assign dec_clear  = code == clear_code;
   assign dec_stop   = (code == clear_code + NFC_W'(1)) || (code > nfc_ff)
                       || (!have_prev_ff && code >= clear_code);

   always_comb begin
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
      stat.go_pop    = is_pull && !is_done && (depth_ff != '0);
      stat.go_walk   = is_pull && !is_done && (depth_ff == '0) && have_bits
                       && !dec_clear && !dec_stop && have_prev_ff;
      stat.walk_more = (walk13 >= clear_code) && (walk13 < NFC_W'(TABLE_DEPTH));
   end

   always_comb begin
      pixel_count_in = csr_wr_en ? csr_wr_data : pixel_count_ff;
      depth_in     = depth_ff;
      min_in       = min_ff;
      ccb_in       = ccb_ff;
      nfc_in       = nfc_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      fs_in        = fs_ff;
      acc_in       = acc_ff;
      bc_in        = bc_ff;
      sbl_in       = sbl_ff;
      pixels_in    = pixels_ff;
      ended_in     = ended_ff;
      walk_in      = walk_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in   = rsp_pix_ff;
      rsp_st_in    = rsp_st_ff;
      tbl_we       = 1'b0;
      stk_we       = 1'b0;
      stk_waddr    = depth_ff[SAW-1:0];
      stk_wdata    = suf_rdata;

      if (cmd.accept) begin
         rsp_pix_in = 8'd0;
         rsp_st_in  = ST_REJECT;
         case (req_mode)
            MODE_START: begin
               if (req_data_byte >= 8'd2 && req_data_byte <= 8'd8) begin
                  min_in       = req_data_byte[CBITS_W-1:0];
                  ccb_in       = req_data_byte[CBITS_W-1:0] + CBITS_W'(1);
                  nfc_in       = (NFC_W'(1) << req_data_byte[CBITS_W-1:0]) + NFC_W'(2);
                  prev_in      = '0;
                  have_prev_in = 1'b0;
                  fs_in        = '0;
                  depth_in     = '0;
                  acc_in       = '0;
                  bc_in        = '0;
                  sbl_in       = '0;
                  pixels_in    = '0;
                  ended_in     = 1'b0;
                  rsp_st_in    = ST_OK;
               end
            end
            MODE_PUSH: begin
               if (!ended_ff) begin
                  if (sbl_ff == '0) begin
                     if (req_data_byte == '0) begin
                        ended_in = 1'b1;
                     end else begin
                        sbl_in = req_data_byte;
                     end
                     rsp_st_in = ST_OK;
                  end else if (bc_ff <= BCNT_W'(12)) begin
                     acc_in    = acc_ff | (ACC_W'(req_data_byte) << bc_ff);
                     bc_in     = bc_ff + BCNT_W'(8);
                     sbl_in    = sbl_ff - 8'd1;
                     rsp_st_in = ST_OK;
                  end
               end
            end
            MODE_PULL: begin
               if (is_done) begin
                  rsp_st_in = ST_DONE;
               end else if (depth_ff != '0) begin
                  rsp_st_in = ST_PIXEL; // word loaded on pop_out
               end else if (have_bits) begin
                  acc_in    = acc_ff >> ccb_ff;
                  bc_in     = bc_ff - {1'b0, ccb_ff};
                  rsp_st_in = ST_CONTROL;
                  if (dec_clear) begin
                     ccb_in       = min_ff + CBITS_W'(1);
                     nfc_in       = clear_code + NFC_W'(2);
                     have_prev_in = 1'b0;
                  end else if (dec_stop) begin
                     ended_in = 1'b1;
                     acc_in   = '0;
                     bc_in    = '0;
                  end else if (!have_prev_ff) begin
                     fs_in        = code[7:0];
                     prev_in      = code[CODE_W-1:0];
                     have_prev_in = 1'b1;
                     pixels_in    = pixels_ff + PIX_W'(1);
                     rsp_pix_in   = code[7:0];
                     rsp_st_in    = ST_PIXEL;
                  end else begin
                     cur_in = code[CODE_W-1:0];
                     if (code == nfc_ff) begin
                        // KwKwK: string is previous plus its own first symbol
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = fs_ff;
                        depth_in  = SDW'(1);
                        walk_in   = prev_ff;
                     end else begin
                        walk_in = code[CODE_W-1:0];
                     end
                  end
               end else if (ended_ff) begin
                  pixels_in = pixels_ff + PIX_W'(1);
                  rsp_st_in = ST_PAD;
               end else begin
                  rsp_st_in = ST_NEED;
               end
            end
            default: begin
               rsp_st_in = ST_REJECT;
            end
         endcase
         rsp_valid_in = !(stat.go_pop || stat.go_walk);
      end

      if (cmd.pop_out) begin
         depth_in     = depth_m1;
         pixels_in    = pixels_ff + PIX_W'(1);
         rsp_pix_in   = stk_rdata;
         rsp_st_in    = ST_PIXEL;
         rsp_valid_in = 1'b1;
      end

      if (cmd.walk_step) begin
         stk_we   = 1'b1;
         depth_in = depth_ff + SDW'(1);
         walk_in  = pre_rdata;
      end

      if (cmd.finish) begin
         fs_in        = walk_ff[7:0];
         prev_in      = cur_ff;
         pixels_in    = pixels_ff + PIX_W'(1);
         rsp_pix_in   = walk_ff[7:0];
         rsp_st_in    = ST_PIXEL;
         rsp_valid_in = 1'b1;
         if (nfc_ff < NFC_W'(TABLE_DEPTH)) begin
            tbl_we = 1'b1;
            nfc_in = nfc_inc;
            if ((nfc_inc & mask) == '0 && ccb_ff < CBITS_W'(MAX_CODE_BITS)) begin
               ccb_in = ccb_ff + CBITS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= PIX_W'(1);
         depth_ff       <= '0;
         min_ff         <= CBITS_W'(2);
         ccb_ff         <= CBITS_W'(3);
         nfc_ff         <= NFC_W'(6);
         prev_ff        <= '0;
         have_prev_ff   <= 1'b0;
         fs_ff          <= '0;
         acc_ff         <= '0;
         bc_ff          <= '0;
         sbl_ff         <= '0;
         pixels_ff      <= '0;
         ended_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pixel_count_ff <= pixel_count_in;
         depth_ff       <= depth_in;
         min_ff         <= min_in;
         ccb_ff         <= ccb_in;
         nfc_ff         <= nfc_in;
         prev_ff        <= prev_in;
         have_prev_ff   <= have_prev_in;
         fs_ff          <= fs_in;
         acc_ff         <= acc_in;
         bc_ff          <= bc_in;
         sbl_ff         <= sbl_in;
         pixels_ff      <= pixels_in;
         ended_ff       <= ended_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff    <= walk_in;
      cur_ff     <= cur_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_st_ff  <= rsp_st_in;
   end

   gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_prefix (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (nfc_ff[TAW-1:0]),
      .wr_data (prev_ff),
      .rd_addr (walk_ff[TAW-1:0]),
      .rd_data (pre_rdata)
   );

   gld_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_suffix (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (nfc_ff[TAW-1:0]),
      .wr_data (walk_ff[7:0]),
      .rd_addr (walk_ff[TAW-1:0]),
      .rd_data (suf_rdata)
   );

   gld_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH + 1)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (depth_m1[SAW-1:0]),
      .rd_data (stk_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_pix_ff;
   assign rsp_status      = rsp_st_ff;

endmodule

>>> rtl/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Host-driven variable-width LZW decoder for GIF image data.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/stall): mode 0 starts a frame with the minimum code
//    size, mode 1 pushes one stream byte (sub-block lengths included),
//    mode 2 pulls one result. Each request word gives exactly one rsp word.
//  - rsp channel: pixel_index plus status (pixel, need byte, control code,
//    padding, frame done, accepted, rejected).
//  - csr: the user writes pixel_count only while the block is idle; the block
//    itself does not enforce this.
// Timing: start, push and most pulls answer on the next cycle. A pull
//  that pops the stack passes through POP for its registered stack read. A
//  pull that decodes a table code runs WALK_CHK, then WALK_DAT and WALK_CHK
//  per chain link (one registered prefix/suffix read each), then FINISH.
// Reset: synchronous; decoder returns to its power-up state, tables and
//  stack contents are left as they are (only written entries are read).
// Stall: the result sits in an output register; a new request is taken
//  only in IDLE, when that register is empty or drained in the same cycle.
// ----------------------------------------------------------------------------
module gif_lzw_decoder
   import gld_pkg::*;
#(
   parameter int TABLE_DEPTH   = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_pixel_index,
   output logic [2:0]       rsp_status,
   input  logic             csr_wr_en,
   input  logic [PIX_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   gld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   gld_dpath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .rsp_stall       (rsp_stall),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_status      (rsp_status)
   );

   // a request is never taken while an old result is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
      else $error("request accepted over a stalled result");

   // only real pixels carry a non-zero index
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_PIXEL) |-> (rsp_pixel_index == 8'd0))
      else $error("non-pixel result with non-zero index");

   // status code stays within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_REJECT))
      else $error("undefined status code");

endmodule

>>> sim/tb_gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// tb_gif_lzw_decoder
// Self-checking bench for the GIF LZW decoder: frames are built by a small
// LZW encoder, pushed as sub-blocks and pulled back, each rsp word checked
// against an in-bench model of the decoder.
// ----------------------------------------------------------------------------
module tb_gif_lzw_decoder;
   import gld_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Expected result words, compared in order against the rsp channel.
   class rsp_scoreboard;
      logic [7:0] exp_pix[$];
      logic [2:0] exp_st[$];
      int         errors;
      int         checked;

      function void note_word(logic [7:0] pix, logic [2:0] st);
         exp_pix.push_back(pix);
         exp_st.push_back(st);
      endfunction

      function void check_word(logic [7:0] pix, logic [2:0] st);
         logic [7:0] ep;
         logic [2:0] es;
         checked++;
         if (exp_st.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected rsp word pix=%0d status=%0d", pix, st);
            return;
         end
         ep = exp_pix.pop_front();
         es = exp_st.pop_front();
         if (ep !== pix || es !== st) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: word %0d exp pix=%0d st=%0d, got pix=%0d st=%0d",
                        checked, ep, es, pix, st);
         end
      endfunction

      function int pending();
         return exp_st.size();
      endfunction
   endclass

   localparam int TBL_D = 4096;
   localparam int WDOG  = 40000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_mode = MODE_PULL;
   logic [7:0]       req_data_byte = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_pixel_index;
   logic [2:0]       rsp_status;
   logic             csr_wr_en = 1'b0;
   logic [PIX_W-1:0] csr_wr_data = '0;

   gif_lzw_decoder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_index(rsp_pixel_index), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rsp_scoreboard sb = new();

   // ---- decoder model state --------------------------------------------
   logic [11:0] m_prefix[TBL_D];
   logic [7:0]  m_suffix[TBL_D];
   logic [7:0]  m_stack[TBL_D+1];
   int unsigned m_sp, m_min, m_cbits, m_nfc, m_prev, m_first;
   bit          m_have_prev, m_ended;
   int unsigned m_acc, m_bcnt, m_left, m_emitted, m_pix_count;

   bit quiet;          // set late in the run: no idling on either side
   int items_sent;
   int frames_done;

   function void model_start(int unsigned mb);
      m_min = mb; m_cbits = mb + 1; m_nfc = (1 << mb) + 2;
      m_prev = 0; m_have_prev = 0; m_first = 0; m_sp = 0;
      m_acc = 0; m_bcnt = 0; m_left = 0; m_emitted = 0; m_ended = 0;
   endfunction

   function void model_push_sym(int unsigned s);
      if (m_sp < TBL_D + 1) begin
         m_stack[m_sp] = s[7:0];
         m_sp++;
      end
   endfunction

   function void model_stop();
      m_ended = 1; m_acc = 0; m_bcnt = 0;
   endfunction

   // Decodes one code; returns 1 when pixels were stacked.
   function bit model_decode();
      int unsigned clr, mask, code, cur, guard;
      clr  = 1 << m_min;
      mask = (1 << m_cbits) - 1;
      code = m_acc & mask;
      m_acc  = m_acc >> m_cbits;
      m_bcnt = m_bcnt - m_cbits;
      if (code == clr) begin
         m_cbits = m_min + 1; m_nfc = clr + 2; m_have_prev = 0;
         return 0;
      end
      if (code == clr + 1 || code > m_nfc) begin
         model_stop();
         return 0;
      end
      if (!m_have_prev) begin
         if (code >= clr) begin
            model_stop();
            return 0;
         end
         model_push_sym(code);
         m_first = code; m_prev = code; m_have_prev = 1;
         return 1;
      end
      cur = code;
      if (code == m_nfc) begin   // KwKwK: string not yet in the table
         model_push_sym(m_first);
         code = m_prev;
      end
      guard = 0;
      while (code >= clr && code < TBL_D && guard < TBL_D) begin
         model_push_sym(m_suffix[code]);
         code = m_prefix[code];
         guard++;
      end
      m_first = code & 8'hFF;
      model_push_sym(m_first);
      if (m_nfc < TBL_D) begin
         m_prefix[m_nfc] = m_prev[11:0];
         m_suffix[m_nfc] = m_first[7:0];
         m_nfc++;
         if ((m_nfc & mask) == 0 && m_cbits < 12) m_cbits++;
      end
      m_prev = cur & 12'hFFF;
      return 1;
   endfunction

   // Expected rsp word for one accepted request word.
   task automatic predict_word(input logic [1:0] mode, input logic [7:0] b,
                               output logic [7:0] pix, output logic [2:0] st);
      pix = '0; st = ST_REJECT;
      case (mode)
         MODE_START: begin
            if (b >= 2 && b <= 8) begin
               model_start(b);
               st = ST_OK;
            end
         end
         MODE_PUSH: begin
            if (!m_ended) begin
               if (m_left == 0) begin
                  if (b == 0) m_ended = 1;
                  else m_left = b;
                  st = ST_OK;
               end else if (m_bcnt <= 12) begin
                  m_acc = m_acc | (int'(b) << m_bcnt);
                  m_bcnt += 8; m_left--;
                  st = ST_OK;
               end
            end
         end
         MODE_PULL: begin
            if (m_emitted >= m_pix_count) st = ST_DONE;
            else if (m_sp > 0) begin
               m_sp--; pix = m_stack[m_sp]; m_emitted++; st = ST_PIXEL;
            end else if (m_bcnt >= m_cbits) begin
               if (model_decode() && m_sp > 0) begin
                  m_sp--; pix = m_stack[m_sp]; m_emitted++; st = ST_PIXEL;
               end else st = ST_CONTROL;
            end else if (m_ended) begin
               m_emitted++; st = ST_PAD;
            end else st = ST_NEED;
         end
         default: ;
      endcase
   endtask

   // ---- request driver -------------------------------------------------
   // valid stays up between back-to-back words; it drops only for an idle
   // burst or when the bench drains.
   task automatic send_word(input logic [1:0] mode, input logic [7:0] b);
      logic [7:0] p;
      logic [2:0] s;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // word accepted at this edge
      predict_word(mode, b, p, s);
      sb.note_word(p, s);
      items_sent++;
   endtask

   // Waits until all results are in and the decoder has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_pixel_count(input int unsigned n);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n[PIX_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      m_pix_count = n;
   endtask

   // ---- rsp side: random stall bursts, check on accept -----------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_word(rsp_pixel_index, rsp_status);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_stall  <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // Watchdog: cycles with no word moving on either channel.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
         $display("ERROR: watchdog expired, %0d words outstanding", sb.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---- LZW encoder that builds well-formed streams --------------------
   int          code_q[$];
   int          width_q[$];
   logic [7:0]  stream_q[$];

   // Encodes pixels with GIF width rules; optional mid-stream clear.
   task automatic encode_frame(input int mb, input int npix, input int palette,
                               input bit mid_clear);
      int          dict[string];
      string       w, wc;
      int          clr, nfc, cw, i, px;
      byte         pix_arr[];
      code_q.delete(); width_q.delete();
      clr = 1 << mb;
      cw = mb + 1; nfc = clr + 2;
      code_q.push_back(clr); width_q.push_back(cw);
      pix_arr = new[npix];
      for (i = 0; i < npix; i++) begin
         // runs raise the odds of long chains and KwKwK codes
         if (i > 0 && $urandom_range(0, 2) != 0) pix_arr[i] = pix_arr[i-1];
         else pix_arr[i] = byte'($urandom_range(0, palette - 1));
      end
      w = "";
      for (i = 0; i < npix; i++) begin
         px = pix_arr[i] & 8'hFF;
         wc = {w, string'(byte'(px + 1))};
         if (w.len() == 0 || dict.exists(wc) || (wc.len() == 1)) begin
            w = wc;
         end else begin
            code_q.push_back(w.len() == 1 ? w[0] - 1 : dict[w]);
            width_q.push_back(cw);
            if (nfc < TBL_D) begin
               dict[wc] = nfc;
               nfc++;
               if (nfc == (1 << cw) + 1 && cw < 12) cw++;
            end
            w = string'(byte'(px + 1));
            if (mid_clear && i == npix / 2) begin
               code_q.push_back(w.len() == 1 ? w[0] - 1 : dict[w]);
               width_q.push_back(cw);
               code_q.push_back(clr); width_q.push_back(cw);
               dict.delete();
               cw = mb + 1; nfc = clr + 2; w = "";
            end
         end
      end
      if (w.len() > 0) begin
         code_q.push_back(w.len() == 1 ? w[0] - 1 : dict[w]);
         width_q.push_back(cw);
      end
      code_q.push_back(clr + 1); width_q.push_back(cw);
   endtask

   // Packs codes LSB first and cuts them into sub-blocks.
   task automatic pack_stream();
      logic [7:0] data_q[$];
      int unsigned acc;
      int bits, i, n;
      data_q.delete(); stream_q.delete();
      acc = 0; bits = 0;
      foreach (code_q[k]) begin
         acc = acc | (code_q[k] << bits);
         bits += width_q[k];
         while (bits >= 8) begin
            data_q.push_back(acc[7:0]);
            acc = acc >> 8; bits -= 8;
         end
      end
      if (bits > 0) data_q.push_back(acc[7:0]);
      i = 0;
      while (i < data_q.size()) begin
         n = $urandom_range(1, 12);
         if (n > data_q.size() - i) n = data_q.size() - i;
         stream_q.push_back(n[7:0]);
         repeat (n) begin
            stream_q.push_back(data_q[i]);
            i++;
         end
      end
      stream_q.push_back(8'd0);
   endtask

   // Runs one frame: interleaves pushes and pulls, pulls past the end.
   task automatic run_frame(input int mb, input int npix, input int palette,
                            input bit mid_clear, input bit corrupt);
      int idx;
      encode_frame(mb, npix, palette, mid_clear);
      pack_stream();
      if (corrupt) begin
         idx = $urandom_range(0, stream_q.size() - 1);
         stream_q[idx] = 8'($urandom_range(0, 255));
      end
      send_word(MODE_START, mb[7:0]);
      idx = 0;
      while (idx < stream_q.size() || m_emitted < m_pix_count) begin
         if (idx < stream_q.size() && ($urandom_range(0, 2) != 0 || m_bcnt < 12)) begin
            send_word(MODE_PUSH, stream_q[idx]);
            // a refused push leaves the byte for the next try
            if (sb.exp_st[$] == ST_OK) idx++;
            else if (m_emitted >= m_pix_count) idx = stream_q.size();
            if (m_ended && idx < stream_q.size()) idx = stream_q.size();
         end else begin
            send_word(MODE_PULL, 8'($urandom_range(0, 255)));
            // stream used up with no end seen: nothing more can come out
            if (idx >= stream_q.size() && sb.exp_st[$] == ST_NEED) break;
         end
      end
      send_word(MODE_PULL, 8'h00);   // frame done
      frames_done++;
   endtask

   // ---- stimulus -------------------------------------------------------
   initial begin
      int i, mb, np;
      quiet = 0; items_sent = 0; frames_done = 0;
      m_pix_count = 1;
      model_start(2);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bad starts, reserved mode, pull/push before data.
      send_word(MODE_PULL, 8'hFF);           // one padding-free: needs byte
      send_word(MODE_START, 8'd0);
      send_word(MODE_START, 8'd1);
      send_word(MODE_START, 8'd9);
      send_word(MODE_START, 8'hFF);
      send_word(2'd3, 8'hA5);
      send_word(MODE_START, 8'd8);
      send_word(MODE_PULL, 8'h00);
      send_word(MODE_PUSH, 8'd0);            // zero length ends the data
      send_word(MODE_PUSH, 8'h55);           // refused after end
      send_word(MODE_PULL, 8'h00);           // padding
      send_word(MODE_PULL, 8'h00);           // frame done
      // Overfilled accumulator: data byte refused.
      send_word(MODE_START, 8'd2);
      send_word(MODE_PUSH, 8'd255);
      send_word(MODE_PUSH, 8'hFF);
      send_word(MODE_PUSH, 8'hAA);
      send_word(MODE_PUSH, 8'h00);
      write_pixel_count(4);
      // End code as the first code: decoding stops, rest is padding.
      send_word(MODE_START, 8'd2);
      send_word(MODE_PUSH, 8'd1);
      send_word(MODE_PUSH, 8'h05);           // code 5 is the end code (clear + 1)
      for (i = 0; i < 5; i++) send_word(MODE_PULL, 8'h00);

      // Directed frames at the code size extremes, KwKwK runs included.
      write_pixel_count(12);
      run_frame(2, 12, 4, 0, 0);
      write_pixel_count(40);
      run_frame(8, 40, 256, 1, 0);

      // Random frames; the odd longer frame widens the codes.
      while (items_sent < 1050) begin
         mb = $urandom_range(2, 8);
         np = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 1200)
                                           : $urandom_range(1, 60);
         // keep the word count near the budget
         if (np > (1100 - items_sent) / 2) np = (1100 - items_sent) / 2;
         if (items_sent > 900) quiet = 1;
         write_pixel_count(np + $urandom_range(0, 1) * $urandom_range(0, 3));
         run_frame(mb, np, 1 << $urandom_range(1, mb), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 7) == 0);
      end
      // Widest pixel count value: frame never completes, only padding.
      write_pixel_count(25'h1FFFFFF);
      send_word(MODE_START, 8'd2);
      send_word(MODE_PUSH, 8'd0);
      send_word(MODE_PULL, 8'h00);
      write_pixel_count(25'd16777216);
      send_word(MODE_PULL, 8'h00);

      drain();
      $display("Run covered %0d request words over %0d frames, %0d rsp words checked.",
               items_sent, frames_done, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else begin
         $display("ERROR: %0d mismatches, %0d words missing", sb.errors, sb.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/gld_pkg.sv
rtl/gld_ram.sv
rtl/gld_ctrl.sv
rtl/gld_dpath.sv
rtl/gif_lzw_decoder.sv
sim/tb_gif_lzw_decoder.sv
